>>> rtl/aabb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

    localparam int MaxObjects = 64;
    localparam int IdxW       = $clog2(MaxObjects);
    localparam int CntW       = IdxW + 1;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_RESOLVE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic        [30:0] w;
        logic        [30:0] h;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_entry;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         entry_index;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic        [30:0] box_width;
        logic        [30:0] box_height;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         resolved_index;
        logic signed [31:0] new_centre_x;
        logic signed [31:0] new_centre_y;
        logic               hit_x;
        logic               hit_y;
    } t_out_item;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'sd2147483647) begin
                r = 32'sh7FFFFFFF;
            end else if (v < -34'sd2147483648) begin
                r = 32'sh80000000;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

    // one axis of the overlap rule; c1/c2 signed, h1/h2 half sizes
    function automatic logic axis_hit(input logic signed [31:0] c1,
                                      input logic [29:0] h1,
                                      input logic signed [31:0] c2,
                                      input logic [29:0] h2,
                                      input logic [15:0] m);
        logic signed [33:0] lo1, hi1, lo2, hi2, mm;
        begin
            lo1 = 34'(c1) - 34'(signed'({1'b0, h1}));
            hi1 = 34'(c1) + 34'(signed'({1'b0, h1}));
            lo2 = 34'(c2) - 34'(signed'({1'b0, h2}));
            hi2 = 34'(c2) + 34'(signed'({1'b0, h2}));
            mm  = 34'(signed'({1'b0, m}));
            return ((lo1 > lo2) && (lo1 < hi2 - mm)) ||
                   ((hi1 < hi2) && (hi1 > lo2 + mm)) ||
                   (lo1 == lo2) || (hi1 == hi2);
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/aabb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aabb_in_if;
    logic                valid;
    logic                ready;
    aabb_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface aabb_out_if;
    logic                valid;
    logic                ready;
    aabb_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface aabb_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/aabb_collision_resolve.sv
`timescale 1ns / 1ps
`default_nettype none
// Load, clear, out-of-range resolve and ignored actions finish at acceptance; the block stays idle.
// A resolve goes through fetch, a read of each table entry, a drain, the ST_CLIP state and
// write-back, which loads its result; each clipping entry stalls the walk of the table.
// The next transaction is taken once write-back has returned the block to idle.
// A waiting result holds a finished resolve in write-back; loads and clears wait as well.
// Synchronous active-low reset clears entry_count, error_margin and control; table kept.
module aabb_collision_resolve (
    input  wire          i_clk,
    input  wire          i_rst_n,
    aabb_in_if.sink      in_ch,
    aabb_out_if.source   out_ch,
    aabb_cfg_if.sink     cfg_ch
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_WALK, ST_CLIP, ST_WB, ST_OUT
    } t_state;

    // Box table: one synchronous memory, one read port.
    aabb_pkg::t_entry mem [aabb_pkg::MaxObjects];

    t_state                    r_state;
    logic [aabb_pkg::CntW-1:0] r_count;
    logic [15:0]               r_margin;
    logic [aabb_pkg::IdxW-1:0] r_idx;
    logic [aabb_pkg::CntW-1:0] r_k;       // next address to read
    logic [aabb_pkg::IdxW-1:0] r_kd;      // address of the data now in r_rd
    logic                      r_rd_vld;
    aabb_pkg::t_entry          r_rd;
    aabb_pkg::t_entry          r_own;
    logic signed [31:0]        r_vx, r_vy;
    logic                      r_hx, r_hy;
    // registered hit flags of the previous step, clip done next cycle
    logic                      r_cx_en, r_cy_en;
    aabb_pkg::t_entry          r_oth;
    logic                      r_ovld;
    aabb_pkg::t_out_item       r_out;

    logic                      mem_we;
    logic [aabb_pkg::IdxW-1:0] mem_wa, mem_ra;
    aabb_pkg::t_entry          mem_wd;
    logic                      acc;
    logic                      out_free;

    assign in_ch.ready  = (r_state == ST_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign acc          = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = r_ovld;
    assign out_ch.payload = r_out;
    // output register can take a new result this cycle
    assign out_free     = !r_ovld || out_ch.ready;

    // overlap test of moved box against the entry just read
    logic signed [31:0] nx, ny;
    logic               full_hit, x_hit, y_hit;
    logic [29:0]        hw1, hh1, hw2, hh2;
    always_comb begin
        nx  = aabb_pkg::sat34(34'(r_own.cx) + 34'(r_vx));
        ny  = aabb_pkg::sat34(34'(r_own.cy) + 34'(r_vy));
        hw1 = r_own.w[30:1];
        hh1 = r_own.h[30:1];
        hw2 = r_rd.w[30:1];
        hh2 = r_rd.h[30:1];
        full_hit = aabb_pkg::axis_hit(nx, hw1, r_rd.cx, hw2, r_margin) &&
                   aabb_pkg::axis_hit(ny, hh1, r_rd.cy, hh2, r_margin);
        x_hit = full_hit &&
                aabb_pkg::axis_hit(nx, hw1, r_rd.cx, hw2, r_margin) &&
                aabb_pkg::axis_hit(r_own.cy, hh1, r_rd.cy, hh2, r_margin);
        y_hit = full_hit &&
                aabb_pkg::axis_hit(r_own.cx, hw1, r_rd.cx, hw2, r_margin) &&
                aabb_pkg::axis_hit(ny, hh1, r_rd.cy, hh2, r_margin);
    end

    // clip of the hit recorded last cycle
    logic signed [33:0] clx, cly;
    always_comb begin
        if (r_vx > 32'sd0) begin
            clx = -((34'(r_own.cx) - 34'(r_oth.cx)) + 34'(signed'({1'b0, r_own.w[30:1]}))
                    + 34'(signed'({1'b0, r_oth.w[30:1]})));
        end else begin
            clx = -((34'(r_own.cx) - 34'(r_oth.cx)) - 34'(signed'({1'b0, r_own.w[30:1]}))
                    - 34'(signed'({1'b0, r_oth.w[30:1]})));
        end
        if (r_vy > 32'sd0) begin
            cly = -((34'(r_own.cy) - 34'(r_oth.cy)) + 34'(signed'({1'b0, r_own.h[30:1]}))
                    + 34'(signed'({1'b0, r_oth.h[30:1]})));
        end else begin
            cly = -((34'(r_own.cy) - 34'(r_oth.cy)) - 34'(signed'({1'b0, r_own.h[30:1]}))
                    - 34'(signed'({1'b0, r_oth.h[30:1]})));
        end
    end

    // walk: a hit stalls the read stream so the clip lands
    // before the next entry is tested (the velocity carries forward)
    logic pend;
    assign pend = r_cx_en || r_cy_en;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_idx;
        mem_wd = r_own;
        mem_ra = r_k[aabb_pkg::IdxW-1:0];
        if (acc && in_ch.payload.action == aabb_pkg::ACT_LOAD) begin
            mem_we = 1'b1;
            mem_wa = in_ch.payload.entry_index;
            mem_wd = '{in_ch.payload.centre_x, in_ch.payload.centre_y,
                       in_ch.payload.box_width, in_ch.payload.box_height,
                       in_ch.payload.velocity_x, in_ch.payload.velocity_y};
        end else if (acc) begin
            mem_ra = in_ch.payload.entry_index;
        end else if (r_state == ST_WB) begin
            mem_we    = 1'b1;
            mem_wd.cx = aabb_pkg::sat34(34'(r_own.cx) + 34'(r_vx));
            mem_wd.cy = aabb_pkg::sat34(34'(r_own.cy) + 34'(r_vy));
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_margin <= '0;
            r_ovld   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_cx_en  <= 1'b0;
            r_cy_en  <= 1'b0;
            r_k      <= '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                r_margin <= cfg_ch.data;
            end
            // write-back reloads the output register itself
            if (r_ovld && out_ch.ready && (r_state != ST_WB)) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_rd_vld <= 1'b0;
                    if (acc) begin
                        unique case (in_ch.payload.action)
                            aabb_pkg::ACT_LOAD: begin
                                if (r_count < {1'b0, in_ch.payload.entry_index} + 1'b1) begin
                                    r_count <= {1'b0, in_ch.payload.entry_index} + 1'b1;
                                end
                            end
                            aabb_pkg::ACT_CLEAR: r_count <= '0;
                            aabb_pkg::ACT_RESOLVE: begin
                                if ({1'b0, in_ch.payload.entry_index} < r_count) begin
                                    r_idx   <= in_ch.payload.entry_index;
                                    r_state <= ST_FETCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FETCH: begin
                    r_own   <= r_rd;
                    r_vx    <= r_rd.vx;
                    r_vy    <= r_rd.vy;
                    r_hx    <= 1'b0;
                    r_hy    <= 1'b0;
                    r_cx_en <= 1'b0;
                    r_cy_en <= 1'b0;
                    r_k     <= '0;
                    r_rd_vld <= 1'b0;
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (pend) begin
                        // apply clip, then re-issue the entry after the hit
                        if (r_cx_en) begin
                            r_vx <= aabb_pkg::sat34(clx);
                            r_hx <= 1'b1;
                        end
                        if (r_cy_en) begin
                            r_vy <= aabb_pkg::sat34(cly);
                            r_hy <= 1'b1;
                        end
                        r_cx_en  <= 1'b0;
                        r_cy_en  <= 1'b0;
                        r_rd_vld <= 1'b0;
                        r_k      <= {1'b0, r_kd} + 1'b1;
                    end else begin
                        if (r_rd_vld && r_kd != r_idx && full_hit) begin
                            r_cx_en  <= x_hit;
                            r_cy_en  <= y_hit;
                            r_oth    <= r_rd;
                        end
                        if (r_rd_vld && r_kd != r_idx && full_hit && (x_hit || y_hit)) begin
                            r_rd_vld <= 1'b0;
                        end else if (r_k < r_count) begin
                            r_rd_vld <= 1'b1;
                            r_kd     <= r_k[aabb_pkg::IdxW-1:0];
                            r_k      <= r_k + 1'b1;
                        end else begin
                            r_rd_vld <= 1'b0;
                            if (!r_rd_vld) begin
                                r_state <= ST_CLIP;
                            end
                        end
                    end
                end
                ST_CLIP: r_state <= ST_WB;
                ST_WB: begin
                    // hold here while the previous result still waits
                    if (out_free) begin
                        r_out.resolved_index <= r_idx;
                        r_out.new_centre_x   <= mem_wd.cx;
                        r_out.new_centre_y   <= mem_wd.cy;
                        r_out.hit_x          <= r_hx;
                        r_out.hit_y          <= r_hy;
                        r_ovld               <= 1'b1;
                        r_state              <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/aabb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module aabb_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire in_valid,
    input wire in_ready,
    input wire out_valid,
    input wire out_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_ready_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready && !in_valid |=> in_ready) else $error("ready dropped while idle");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result after reset");
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a walk");
endmodule

bind aabb_collision_resolve aabb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int IdleLimit = 5000;   // cycles with no transaction at all
    localparam int DrainWait = 80;     // extra wait once every queue has drained
    localparam int LongHold  = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    aabb_in_if  in_bus();
    aabb_out_if out_bus();
    aabb_cfg_if cfg_bus();

    aabb_collision_resolve u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_bus.sink),
        .out_ch (out_bus.source),
        .cfg_ch (cfg_bus.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: box table, walk length and overlap tolerance
    logic signed [31:0] box_cx [aabb_pkg::MaxObjects];
    logic signed [31:0] box_cy [aabb_pkg::MaxObjects];
    logic        [30:0] box_w  [aabb_pkg::MaxObjects];
    logic        [30:0] box_h  [aabb_pkg::MaxObjects];
    logic signed [31:0] box_vx [aabb_pkg::MaxObjects];
    logic signed [31:0] box_vy [aabb_pkg::MaxObjects];
    int unsigned        live_count = 0;
    longint             margin = 0;

    aabb_pkg::t_in_item  pending_items [$];
    aabb_pkg::t_out_item expected_moves [$];

    int  error_count = 0;
    int  moves_seen = 0;
    int  hits_seen = 0;
    int  loads_sent = 0;
    int  gen_count = 0;          // entry_count as seen by the stimulus generator
    bit  in_acc = 1'b0;
    int  send_gap = 0;
    int  recv_hold = 0;
    bit  long_hold_done = 1'b0;

    function automatic longint sat_i32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit span_hit(longint c1, longint h1, longint c2, longint h2);
        longint lo1, hi1, lo2, hi2;
        lo1 = c1 - h1; hi1 = c1 + h1;
        lo2 = c2 - h2; hi2 = c2 + h2;
        return (lo1 > lo2 && lo1 < hi2 - margin) || (hi1 < hi2 && hi1 > lo2 + margin) ||
               lo1 == lo2 || hi1 == hi2;
    endfunction

    function automatic bit box_touches(longint x1, longint y1, longint w1, longint h1, int k);
        return span_hit(x1, w1 >> 1, longint'(box_cx[k]), longint'({1'b0, box_w[k]}) >> 1) &&
               span_hit(y1, h1 >> 1, longint'(box_cy[k]), longint'({1'b0, box_h[k]}) >> 1);
    endfunction

    function automatic longint stop_flush(longint vel, longint p, longint q,
                                          longint s1, longint s2);
        longint d;
        d = (vel > 0) ? 1 : -1;
        return sat_i32(-((p - q + d * (s1 >> 1)) + d * (s2 >> 1)));
    endfunction

    // apply one accepted transaction; queue the resolved move if one is due
    task automatic apply_item(aabb_pkg::t_in_item it);
        longint px, py, w, h, vx, vy, nx, ny;
        bit hx, hy, xo, yo;
        int idx;
        aabb_pkg::t_out_item mv;
        idx = it.entry_index;
        case (aabb_pkg::t_action'(it.action))
            aabb_pkg::ACT_CLEAR: live_count = 0;
            aabb_pkg::ACT_LOAD: begin
                box_cx[idx] = it.centre_x;   box_cy[idx] = it.centre_y;
                box_w[idx]  = it.box_width;  box_h[idx]  = it.box_height;
                box_vx[idx] = it.velocity_x; box_vy[idx] = it.velocity_y;
                if (live_count < idx + 1) live_count = idx + 1;
            end
            aabb_pkg::ACT_RESOLVE: begin
                if (idx < live_count) begin
                    px = box_cx[idx]; py = box_cy[idx];
                    w = {1'b0, box_w[idx]}; h = {1'b0, box_h[idx]};
                    vx = box_vx[idx]; vy = box_vy[idx];
                    hx = 0; hy = 0;
                    for (int k = 0; k < live_count; k++) begin
                        if (k == idx) continue;
                        nx = sat_i32(px + vx);
                        ny = sat_i32(py + vy);
                        if (box_touches(nx, ny, w, h, k)) begin
                            xo = box_touches(nx, py, w, h, k);
                            yo = box_touches(px, ny, w, h, k);
                            if (xo) begin
                                vx = stop_flush(vx, px, box_cx[k], w, {1'b0, box_w[k]});
                                hx = 1;
                            end
                            if (yo) begin
                                vy = stop_flush(vy, py, box_cy[k], h, {1'b0, box_h[k]});
                                hy = 1;
                            end
                        end
                    end
                    px = sat_i32(px + vx);
                    py = sat_i32(py + vy);
                    box_cx[idx] = px[31:0];
                    box_cy[idx] = py[31:0];
                    mv.resolved_index = idx[5:0];
                    mv.new_centre_x = px[31:0];
                    mv.new_centre_y = py[31:0];
                    mv.hit_x = hx;
                    mv.hit_y = hy;
                    expected_moves = {expected_moves, mv};
                end
            end
            default: ;
        endcase
    endtask

    // monitor: accept inputs, configuration and results at the rising edge
    always @(posedge i_clk) begin
        aabb_pkg::t_out_item want;
        in_acc <= i_rst_n && in_bus.valid && in_bus.ready;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) apply_item(in_bus.payload);
            if (cfg_bus.valid && cfg_bus.ready) margin = longint'(cfg_bus.data);
            if (out_bus.valid && out_bus.ready) begin
                moves_seen++;
                if (out_bus.payload.hit_x || out_bus.payload.hit_y) hits_seen++;
                if (expected_moves.size() == 0) begin
                    $error("result with no transaction outstanding: index %0d",
                           out_bus.payload.resolved_index);
                    error_count++;
                end else begin
                    want = expected_moves.pop_front();
                    if (out_bus.payload.resolved_index !== want.resolved_index) begin
                        $error("resolved_index: expected %0d, got %0d",
                               want.resolved_index, out_bus.payload.resolved_index);
                        error_count++;
                    end
                    if (out_bus.payload.new_centre_x !== want.new_centre_x) begin
                        $error("new_centre_x: expected %h, got %h",
                               want.new_centre_x, out_bus.payload.new_centre_x);
                        error_count++;
                    end
                    if (out_bus.payload.new_centre_y !== want.new_centre_y) begin
                        $error("new_centre_y: expected %h, got %h",
                               want.new_centre_y, out_bus.payload.new_centre_y);
                        error_count++;
                    end
                    if (out_bus.payload.hit_x !== want.hit_x) begin
                        $error("hit_x: expected %0b, got %0b",
                               want.hit_x, out_bus.payload.hit_x);
                        error_count++;
                    end
                    if (out_bus.payload.hit_y !== want.hit_y) begin
                        $error("hit_y: expected %0b, got %0b",
                               want.hit_y, out_bus.payload.hit_y);
                        error_count++;
                    end
                end
            end
        end
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // driver: advance to the next pending item once the current one is taken
    always @(negedge i_clk) begin
        bit v;
        if (i_rst_n && (!in_bus.valid || in_acc)) begin
            v = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_items.size() > 0) begin
                in_bus.payload <= pending_items.pop_front();
                v = 1'b1;
                send_gap = pick_gap();
            end
            in_bus.valid <= v;
        end
    end

    // receiver: random back-pressure, plus one long hold-off to fill the block
    always @(negedge i_clk) begin
        if (!long_hold_done && moves_seen >= 60) begin
            long_hold_done = 1'b1;
            recv_hold = LongHold;
        end
        if (recv_hold > 0) begin
            recv_hold--;
            out_bus.ready <= 1'b0;
        end else begin
            recv_hold = pick_gap();
            out_bus.ready <= (recv_hold == 0);
        end
    end

    // watchdog: drop out if nothing moves for too long
    always @(posedge i_clk) begin
        int idle;
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            idle = 0;
        end else begin
            idle++;
        end
        if (idle >= IdleLimit) begin
            $display("watchdog: no transaction for %0d cycles", IdleLimit);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic signed [31:0] coord(int span);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [30:0] extent();
        if ($urandom_range(0, 9) == 0) return 31'($urandom);
        return 31'($urandom_range(32'h0000_8000, 32'h000C_0000));
    endfunction

    task automatic queue_item(aabb_pkg::t_action act, int idx, logic signed [31:0] cx,
                              logic signed [31:0] cy, logic [30:0] w, logic [30:0] h,
                              logic signed [31:0] vx, logic signed [31:0] vy);
        aabb_pkg::t_in_item it;
        it.action = act; it.entry_index = idx[5:0];
        it.centre_x = cx; it.centre_y = cy;
        it.box_width = w; it.box_height = h;
        it.velocity_x = vx; it.velocity_y = vy;
        pending_items = {pending_items, it};
        if (act == aabb_pkg::ACT_LOAD) begin
            loads_sent++;
            if (gen_count < idx + 1) gen_count = idx + 1;
        end
        if (act == aabb_pkg::ACT_CLEAR) gen_count = 0;
    endtask

    task automatic queue_load(int idx);
        queue_item(aabb_pkg::ACT_LOAD, idx, coord(32'h0014_0000), coord(32'h0014_0000),
                   extent(), extent(), coord(32'h0004_0000), coord(32'h0004_0000));
    endtask

    // resolves and other non-load items carry random noise in the unused fields
    task automatic queue_plain(aabb_pkg::t_action act, int idx);
        queue_item(act, idx, $urandom, $urandom, 31'($urandom), 31'($urandom),
                   $urandom, $urandom);
    endtask

    task automatic wait_quiet();
        while (pending_items.size() > 0 || in_bus.valid || expected_moves.size() > 0)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic write_margin(logic [15:0] value);
        wait_quiet();
        @(negedge i_clk);
        cfg_bus.data  <= value;
        cfg_bus.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] margins [4];
        int r, idx;
        margins = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000};
        margins[2] = 16'($urandom);
        margins[3] = 16'($urandom_range(1, 16'h0800));
        in_bus.valid = 1'b0;
        in_bus.payload = '0;
        out_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: touching, contained, equal-edge and saturating boxes
        queue_item(aabb_pkg::ACT_LOAD, 0, 32'sh0000_0000, 32'sh0000_0000, 31'h0002_0000,
                   31'h0002_0000, 32'sh0003_0000, 32'sh0000_0000);
        queue_item(aabb_pkg::ACT_LOAD, 1, 32'sh0003_0000, 32'sh0000_0000, 31'h0002_0000,
                   31'h0002_0000, 32'sh0000_0000, 32'sh0000_0000);
        queue_item(aabb_pkg::ACT_LOAD, 2, 32'sh0000_0000, 32'sh0000_0000, 31'h0008_0000,
                   31'h0008_0000, -32'sh0001_0000, 32'sh0001_0000);
        queue_item(aabb_pkg::ACT_LOAD, 3, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF,
                   31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_plain(aabb_pkg::ACT_RESOLVE, 0);
        queue_plain(aabb_pkg::ACT_RESOLVE, 1);
        queue_plain(aabb_pkg::ACT_RESOLVE, 2);
        queue_plain(aabb_pkg::ACT_RESOLVE, 3);
        queue_plain(aabb_pkg::ACT_RESOLVE, 4);           // beyond entry_count: no result
        queue_plain(aabb_pkg::ACT_NONE, 0);
        queue_plain(aabb_pkg::ACT_RESOLVE, 0);
        queue_item(aabb_pkg::ACT_LOAD, 4, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h0, 31'h0,
                   32'sh8000_0000, 32'sh7FFF_FFFF);
        queue_plain(aabb_pkg::ACT_RESOLVE, 4);
        queue_plain(aabb_pkg::ACT_CLEAR, 0);
        queue_plain(aabb_pkg::ACT_RESOLVE, 0);           // table cleared: no result
        // fill every entry once so later walks never read an unwritten box
        for (int k = 0; k < aabb_pkg::MaxObjects; k++) queue_load(k);
        queue_plain(aabb_pkg::ACT_RESOLVE, 63);
        queue_plain(aabb_pkg::ACT_RESOLVE, 10);
        queue_plain(aabb_pkg::ACT_CLEAR, 0);

        for (int phase = 0; phase < 4; phase++) begin
            write_margin(margins[phase]);
            for (int n = 0; n < 375; n++) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    idx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, 7);
                    queue_load(idx);
                end else if (r < 88) begin
                    idx = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, gen_count);
                    queue_plain(aabb_pkg::ACT_RESOLVE, idx);
                end else if (r < 96) begin
                    queue_plain(aabb_pkg::ACT_CLEAR, $urandom_range(0, 63));
                end else begin
                    queue_plain(aabb_pkg::ACT_NONE, $urandom_range(0, 63));
                end
                // hold the sender once per phase until every result is back
                if (n == 200) begin
                    while (pending_items.size() > 0 || in_bus.valid ||
                           expected_moves.size() > 0)
                        @(posedge i_clk);
                end
            end
        end

        wait_quiet();
        $display("covered %0d loads, %0d resolved moves (%0d clipped) over four margins",
                 loads_sent, moves_seen, hits_seen);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
